// File: sv/dbrp_pkg.sv
// shared types and constants of the depth bilinear remap pixel block
`timescale 1ns / 1ps
package dbrp_pkg;

  // field widths
  localparam int DEPTH_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
  localparam int RATIO_BITS       = 16;
  localparam int MODE_BITS        = 2;
  localparam int NUM_TAPS         = 4;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // derived arithmetic widths
  localparam int PROD_BITS   = DEPTH_BITS + WEIGHT_BITS;
  localparam int SUM_BITS    = PROD_BITS + 2;
  localparam int SHIFT_BITS  = SUM_BITS - WEIGHT_FRAC_BITS;
  localparam int SPREAD_BITS = DEPTH_BITS + RATIO_BITS;

  // register indexes
  localparam logic REG_INTERP_MODE = 1'b0;
  localparam logic REG_SKIP_RATIO  = 1'b1;

  // interpolation modes
  localparam logic [MODE_BITS-1:0] MODE_NEAREST  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BILINEAR = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DEPTH    = 2'd2;

  // reset values
  localparam logic [MODE_BITS-1:0]  INTERP_MODE_RESET = MODE_DEPTH;
  localparam logic [RATIO_BITS-1:0] SKIP_RATIO_RESET  = 16'd3076;

  typedef struct packed {
    logic [MODE_BITS-1:0]  interp_mode;
    logic [RATIO_BITS-1:0] skip_ratio;
  } cfg_t;

  typedef struct packed {
    logic                                   entry_valid;
    logic [NUM_TAPS-1:0][DEPTH_BITS-1:0]    depth;
    logic [NUM_TAPS-1:0][WEIGHT_BITS-1:0]   weight;
  } pixel_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic                  filled;
  } result_t;

endpackage

// File: sv/depth_bilinear_remap_pixel.sv
// top level of the depth bilinear remap pixel block
//
// Usage:
//   Configuration goes through the apb port: register 0 at address 0 holds the
//   interpolation mode (0 nearest, 1 bilinear, 2 or 3 bilinear with depth
//   invalidation), register 1 at address 4 the skip ratio in q0.16. Write only
//   while no pixel is in flight.
//   A word is accepted on each rising edge with start high and busy low. busy
//   stays low, so a new word can enter every cycle: one pixel per clock.
//   Each word carries the entry valid mark, four neighbor depths and four
//   q1.16 weights; it is captured in an input register, and the result is
//   registered behind it in the result register, so result_valid pulses for
//   one cycle, with depth_out and was_filled beside it. The delay is set by the
//   input and result registers around the single multiply-add pass.
//   Results come out in order and must be taken in the cycle they appear;
//   the receiver has no way to stall.
//   Reset clears the pipeline valid flags and returns mode 2 with ratio 3076.
`timescale 1ns / 1ps
module depth_bilinear_remap_pixel (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [dbrp_pkg::APB_ADDR_BITS-1:0]        paddr,
  input  logic [dbrp_pkg::APB_DATA_BITS-1:0]        pwdata,
  output logic [dbrp_pkg::APB_DATA_BITS-1:0]        prdata,
  output logic                                      pready,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      entry_valid,
  input  logic [dbrp_pkg::DEPTH_BITS-1:0]           depth_upper_left,
  input  logic [dbrp_pkg::DEPTH_BITS-1:0]           depth_upper_right,
  input  logic [dbrp_pkg::DEPTH_BITS-1:0]           depth_lower_left,
  input  logic [dbrp_pkg::DEPTH_BITS-1:0]           depth_lower_right,
  input  logic [dbrp_pkg::WEIGHT_BITS-1:0]          weight_upper_left,
  input  logic [dbrp_pkg::WEIGHT_BITS-1:0]          weight_upper_right,
  input  logic [dbrp_pkg::WEIGHT_BITS-1:0]          weight_lower_left,
  input  logic [dbrp_pkg::WEIGHT_BITS-1:0]          weight_lower_right,
  output logic                                      result_valid,
  output logic [dbrp_pkg::DEPTH_BITS-1:0]           depth_out,
  output logic                                      was_filled
);
  import dbrp_pkg::*;

  cfg_t    cfg;
  pixel_t  pix;
  pixel_t  pix_next;
  logic    pix_valid;
  logic    accept;
  result_t calc_res;
  result_t res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration registers
  dbrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input word packing
  always_comb begin
    pix_next.entry_valid = entry_valid;
    pix_next.depth[0]    = depth_upper_left;
    pix_next.depth[1]    = depth_upper_right;
    pix_next.depth[2]    = depth_lower_left;
    pix_next.depth[3]    = depth_lower_right;
    pix_next.weight[0]   = weight_upper_left;
    pix_next.weight[1]   = weight_upper_right;
    pix_next.weight[2]   = weight_lower_left;
    pix_next.weight[3]   = weight_lower_right;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= pix_next;
    end
  end

  // pixel datapath
  dbrp_calc u_calc (
    .pix (pix),
    .cfg (cfg),
    .res (calc_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid) begin
      res <= calc_res;
    end
  end

  assign depth_out  = res.depth;
  assign was_filled = res.filled;

  // every accepted word yields a result strobe
  assert property (@(posedge clk) disable iff (rst) accept |=> ##1 result_valid)
    else $error("accepted word produced no result strobe");

  // no strobe without an item in the input register the cycle before
  assert property (@(posedge clk) disable iff (rst) result_valid |-> $past(pix_valid))
    else $error("result strobe without a word in flight");

  // an unfilled pixel always reads as zero depth
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !was_filled) |-> (depth_out == '0))
    else $error("unfilled pixel carries nonzero depth");

  // a valid entry in nearest mode is always filled with the upper left sample
  assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix.entry_valid && cfg.interp_mode == MODE_NEAREST) |=>
      (result_valid && was_filled && depth_out == $past(pix.depth[0])))
    else $error("nearest mode result mismatch");

endmodule

// File: sv/dbrp_cfg.sv
// apb register file holding the interpolation mode and skip ratio
`timescale 1ns / 1ps
module dbrp_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dbrp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [dbrp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [dbrp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output dbrp_pkg::cfg_t                       cfg
);
  import dbrp_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interp_mode <= INTERP_MODE_RESET;
      cfg.skip_ratio  <= SKIP_RATIO_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_INTERP_MODE: cfg.interp_mode <= pwdata[MODE_BITS-1:0];
        REG_SKIP_RATIO:  cfg.skip_ratio  <= pwdata[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_INTERP_MODE: prdata = APB_DATA_BITS'(cfg.interp_mode);
      REG_SKIP_RATIO:  prdata = APB_DATA_BITS'(cfg.skip_ratio);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/dbrp_calc.sv
// combinational pixel datapath: nearest, bilinear and depth-aware bilinear
`timescale 1ns / 1ps
module dbrp_calc (
  input  dbrp_pkg::pixel_t  pix,
  input  dbrp_pkg::cfg_t    cfg,
  output dbrp_pkg::result_t res
);
  import dbrp_pkg::*;

  localparam logic [SUM_BITS-1:0]   ROUND_HALF = SUM_BITS'(1) << (WEIGHT_FRAC_BITS - 1);
  localparam logic [SHIFT_BITS-1:0] SAT_LIMIT  = SHIFT_BITS'((1 << DEPTH_BITS) - 1);

  logic [NUM_TAPS-1:0][PROD_BITS-1:0] prod;
  logic [SUM_BITS-1:0]                sum;
  logic [SHIFT_BITS-1:0]              scaled;
  logic [DEPTH_BITS-1:0]              interp;
  logic [DEPTH_BITS-1:0]              lo;
  logic [DEPTH_BITS-1:0]              hi;
  logic                               any_zero;
  logic [SPREAD_BITS-1:0]             spread_lhs;
  logic [SPREAD_BITS-1:0]             spread_rhs;
  logic                               skip;

  // weighted sum with half-up rounding and saturation
  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      prod[k] = PROD_BITS'(pix.depth[k]) * PROD_BITS'(pix.weight[k]);
      sum     = sum + SUM_BITS'(prod[k]);
    end
    scaled = SHIFT_BITS'((sum + ROUND_HALF) >> WEIGHT_FRAC_BITS);
    interp = (scaled > SAT_LIMIT) ? SAT_LIMIT[DEPTH_BITS-1:0] : scaled[DEPTH_BITS-1:0];
  end

  // min, max and zero detect over the four neighbors
  always_comb begin
    lo       = pix.depth[0];
    hi       = pix.depth[0];
    any_zero = (pix.depth[0] == '0);
    for (int k = 1; k < NUM_TAPS; k++) begin
      if (pix.depth[k] < lo) lo = pix.depth[k];
      if (pix.depth[k] > hi) hi = pix.depth[k];
      if (pix.depth[k] == '0) any_zero = 1'b1;
    end
  end

  // discontinuity test: spread scaled to q16 against ratio times minimum
  assign spread_lhs = SPREAD_BITS'(hi - lo) << RATIO_BITS;
  assign spread_rhs = SPREAD_BITS'(cfg.skip_ratio) * SPREAD_BITS'(lo);
  assign skip       = any_zero || (spread_lhs > spread_rhs);

  // mode select
  always_comb begin
    res.depth  = '0;
    res.filled = 1'b0;
    if (pix.entry_valid) begin
      if (cfg.interp_mode == MODE_NEAREST) begin
        res.depth  = pix.depth[0];
        res.filled = 1'b1;
      end else if (cfg.interp_mode == MODE_BILINEAR) begin
        res.depth  = interp;
        res.filled = 1'b1;
      end else if (!skip) begin
        res.depth  = interp;
        res.filled = 1'b1;
      end
    end
  end

endmodule
